>>> hdl/pfx_pkg.sv
`default_nettype none

package pfx_pkg;

  localparam int DATA_W = 8;
  localparam int STATUS_W = 3;
  localparam int DEFAULT_STACK_DEPTH = 16;

  localparam logic [DATA_W-1:0] CH_0     = 8'h30;
  localparam logic [DATA_W-1:0] CH_9     = 8'h39;
  localparam logic [DATA_W-1:0] CH_PLUS  = 8'h2b;
  localparam logic [DATA_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [DATA_W-1:0] CH_STAR  = 8'h2a;
  localparam logic [DATA_W-1:0] CH_SLASH = 8'h2f;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_UNDERFLOW = 3'd1,
    ST_OVERFLOW  = 3'd2,
    ST_DIVZERO   = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_FROM_UP,
    CELL_FROM_DOWN
  } cell_cmd_t;

endpackage

`default_nettype wire

>>> hdl/pfx_cell.sv
`default_nettype none

module pfx_cell
  import pfx_pkg::*;
(
  input  wire logic              clk,
  input  wire cell_cmd_t         cmd,
  input  wire logic [DATA_W-1:0] from_up,
  input  wire logic [DATA_W-1:0] from_down,
  output logic      [DATA_W-1:0] q
);

  always_ff @(posedge clk) begin
    unique case (cmd)
      CELL_FROM_UP:   q <= from_up;
      CELL_FROM_DOWN: q <= from_down;
      default:        q <= q;
    endcase
  end

endmodule

`default_nettype wire

>>> hdl/pfx_divider.sv
`default_nettype none

module pfx_divider
  import pfx_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [DATA_W-1:0] dividend,
  input  wire logic [DATA_W-1:0] divisor,
  output logic                   done,
  output logic      [DATA_W-1:0] quotient
);

  localparam int STEP_W = $clog2(DATA_W);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] dvs;
  logic [DATA_W:0]   rem_shift;
  logic              fits;

  assign rem_shift = {rem, quotient[DATA_W-1]};
  assign fits      = rem_shift >= {1'b0, dvs};

  // restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy     <= 1'b1;
      step     <= '0;
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      if (fits) begin
        rem <= DATA_W'(rem_shift - {1'b0, dvs});
      end else begin
        rem <= rem_shift[DATA_W-1:0];
      end
      quotient <= {quotient[DATA_W-2:0], fits};
      step     <= step + 1'b1;
      if (step == STEP_W'(DATA_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/postfix_expression_evaluator_top.sv
`default_nettype none

// Postfix evaluator: send one ASCII character per transaction, last_symbol on
// the final one; that transaction yields one result (value, status) and clears
// the stack. The stack is a row of 8-bit cells that shift as a unit, top in
// cell 0, so no clearing pass is needed after reset. One character at a time:
// a digit, + - *, a divide by zero or a symbol that underflows is taken in
// S_IDLE and executed in S_EXEC; an unknown symbol with two operands also
// passes through S_POP2, since it shifts the row twice; a divide by a nonzero
// value waits in S_DIV for the one-bit-per-cycle divider; a last character
// adds S_DONE to load the output register, which waits there on out_ready.
module postfix_expression_evaluator_top
  import pfx_pkg::*;
#(
  parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [DATA_W-1:0]        symbol,
  input  wire logic                     last_symbol,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic signed [DATA_W-1:0]      value,
  output logic        [STATUS_W-1:0]    status
);

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_POP2,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_PUSH,
    OP_POP,
    OP_REPLACE
  } stack_op_t;

  state_t            state;
  logic [DATA_W-1:0] sym_r;
  logic              last_r;
  logic [CNT_W-1:0]  count;
  status_t           sticky;
  logic              neg_r;

  logic [DATA_W-1:0] cell_q [STACK_DEPTH];
  cell_cmd_t         cell_cmd [STACK_DEPTH];
  stack_op_t         stack_op;
  logic [DATA_W-1:0] load_data;

  logic                is_digit;
  logic                full;
  logic                two_avail;
  logic [DATA_W-1:0]   top_val;
  logic [DATA_W-1:0]   nxt_val;
  logic [2*DATA_W-1:0] prod;
  logic [DATA_W-1:0]   a_mag;
  logic [DATA_W-1:0]   b_mag;
  logic                div_start;
  logic                div_done;
  logic [DATA_W-1:0]   div_q;
  logic [DATA_W-1:0]   div_res;
  state_t              after;

  assign in_ready  = state == S_IDLE;
  assign is_digit  = sym_r >= CH_0 && sym_r <= CH_9;
  assign full      = count == CNT_W'(STACK_DEPTH);
  assign two_avail = count >= CNT_W'(2);
  assign top_val   = cell_q[0];
  assign nxt_val   = cell_q[1];
  assign prod      = nxt_val * top_val;
  assign a_mag     = nxt_val[DATA_W-1] ? (~nxt_val + 1'b1) : nxt_val;
  assign b_mag     = top_val[DATA_W-1] ? (~top_val + 1'b1) : top_val;
  assign div_res   = neg_r ? (~div_q + 1'b1) : div_q;
  assign after     = last_r ? S_DONE : S_IDLE;
  assign div_start = state == S_EXEC && !is_digit && two_avail && sym_r == CH_SLASH
                     && top_val != '0;

  always_comb begin
    stack_op  = OP_HOLD;
    load_data = '0;
    case (state)
      S_EXEC: begin
        if (is_digit) begin
          if (!full) begin
            stack_op  = OP_PUSH;
            load_data = sym_r - CH_0;
          end
        end else if (two_avail) begin
          case (sym_r)
            CH_PLUS: begin
              stack_op  = OP_REPLACE;
              load_data = nxt_val + top_val;
            end
            CH_MINUS: begin
              stack_op  = OP_REPLACE;
              load_data = nxt_val - top_val;
            end
            CH_STAR: begin
              stack_op  = OP_REPLACE;
              load_data = prod[DATA_W-1:0];
            end
            CH_SLASH: begin
              if (top_val == '0) begin
                stack_op = OP_REPLACE;
              end
            end
            default: stack_op = OP_POP;
          endcase
        end
      end
      S_DIV: begin
        if (div_done) begin
          stack_op  = OP_REPLACE;
          load_data = div_res;
        end
      end
      S_POP2: stack_op = OP_POP;
      default: stack_op = OP_HOLD;
    endcase
  end

  always_comb begin
    for (int i = 0; i < STACK_DEPTH; i++) begin
      unique case (stack_op)
        OP_PUSH:    cell_cmd[i] = CELL_FROM_UP;
        OP_POP:     cell_cmd[i] = CELL_FROM_DOWN;
        OP_REPLACE: cell_cmd[i] = (i == 0) ? CELL_FROM_UP : CELL_FROM_DOWN;
        default:    cell_cmd[i] = CELL_HOLD;
      endcase
    end
  end

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] up_d;
    logic [DATA_W-1:0] down_d;
    if (i == 0) begin : g_first
      assign up_d = load_data;
    end else begin : g_mid
      assign up_d = cell_q[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_last
      assign down_d = cell_q[i];
    end else begin : g_inner
      assign down_d = cell_q[i+1];
    end
    pfx_cell u_cell (
      .clk       (clk),
      .cmd       (cell_cmd[i]),
      .from_up   (up_d),
      .from_down (down_d),
      .q         (cell_q[i])
    );
  end

  pfx_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (a_mag),
    .divisor  (b_mag),
    .done     (div_done),
    .quotient (div_q)
  );

  function automatic status_t first_err(status_t cur, status_t code);
    return (cur == ST_OK) ? code : cur;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      sticky    <= ST_OK;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            sym_r  <= symbol;
            last_r <= last_symbol;
            state  <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= after;
          if (is_digit) begin
            if (full) begin
              sticky <= first_err(sticky, ST_OVERFLOW);
            end else begin
              count <= count + 1'b1;
            end
          end else if (!two_avail) begin
            sticky <= first_err(sticky, ST_UNDERFLOW);
          end else begin
            case (sym_r) inside
              CH_PLUS, CH_MINUS, CH_STAR: count <= count - 1'b1;
              CH_SLASH: begin
                if (top_val == '0) begin
                  sticky <= first_err(sticky, ST_DIVZERO);
                  count  <= count - 1'b1;
                end else begin
                  neg_r <= nxt_val[DATA_W-1] ^ top_val[DATA_W-1];
                  state <= S_DIV;
                end
              end
              default: begin
                count <= count - 1'b1;
                state <= S_POP2;
              end
            endcase
          end
        end
        S_DIV: begin
          if (div_done) begin
            count <= count - 1'b1;
            state <= after;
          end
        end
        S_POP2: begin
          count <= count - 1'b1;
          state <= after;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            value     <= (count != '0) ? top_val : '0;
            status    <= (count == '0 && sticky == ST_OK) ? ST_EMPTY : sticky;
            count     <= '0;
            sticky    <= ST_OK;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished outside divide state");

  a_result_clears: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE && count == '0 && sticky == ST_OK)
    else $error("result transaction without stack clear");

  a_empty_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_EMPTY |-> value == '0)
    else $error("empty result with nonzero value");

endmodule

`default_nettype wire
